FILE: rtl/feedback_decoder_belief_partition_unit_macros.svh
// Assertion macros for the RTL of the decoder unit.
`ifndef FEEDBACK_DECODER_BELIEF_PARTITION_UNIT_MACROS_SVH
`define FEEDBACK_DECODER_BELIEF_PARTITION_UNIT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define FDBP_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FDBP_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fdbp_pkg.sv
// ----------------------------------------------------------------------------
// fdbp_pkg
// Types, constants and codes of the belief partition decoder.
// ----------------------------------------------------------------------------
package fdbp_pkg;

  localparam int NUM_MESSAGES_DEF = 16;
  localparam int BELIEF_FRAC_BITS_DEF = 24;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_CROSSOVER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 2'd2;

  localparam logic [15:0] CROSSOVER_RST = 16'd3280;
  localparam logic [24:0] STOP_THRESHOLD_RST = 25'd16760439;
  localparam logic [11:0] MAX_STEPS_RST = 12'd113;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_GUARD = 2'd3;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BIT = 1'b1;

  typedef struct packed {
    logic       action;
    logic       rx_bit;
  } in_req_t;

  typedef struct packed {
    logic [15:0] next_tx_mask;
    logic        decided;
    logic [3:0]  decoded_index;
    logic [24:0] max_belief;
    logic [11:0] steps_used;
    logic [1:0]  status;
  } out_req_t;

endpackage

FILE: rtl/fdbp_if.sv
// ----------------------------------------------------------------------------
// fdbp_if
// Valid and ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface fdbp_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/fdbp_divider.sv
// ----------------------------------------------------------------------------
// fdbp_divider
// Restoring divider, one quotient bit per cycle: floor(num * 2^F / den).
// ----------------------------------------------------------------------------
module fdbp_divider #(
  parameter int NUM_W = 48,
  parameter int FRAC = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic             done,
  output logic [FRAC:0]    quot
);
  localparam int STEPS = NUM_W + FRAC;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [NUM_W+FRAC-1:0] sh_r, sh_nxt;
  logic [NUM_W:0]        rem_r, rem_nxt;
  logic [NUM_W-1:0]      den_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [NUM_W:0]        trial;

  always_comb begin
    sh_nxt = sh_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[NUM_W-1:0], sh_r[NUM_W+FRAC-1]};
    if (start) begin
      sh_nxt = {num, {FRAC{1'b0}}};
      rem_nxt = '0;
      cnt_nxt = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        sh_nxt = {sh_r[NUM_W+FRAC-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        sh_nxt = {sh_r[NUM_W+FRAC-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign quot = sh_nxt[FRAC:0];
endmodule

FILE: rtl/feedback_decoder_belief_partition_unit.sv
// ----------------------------------------------------------------------------
// feedback_decoder_belief_partition_unit
// Feedback decoder over a binary symmetric channel with belief partitioning.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                   | Handshake
// in      | in  | action, rx_bit                            | valid/ready
// out     | out | next_tx_mask, decided, decoded_index, ... | valid/ready
// cfg     | in  | index, data                               | write enable
//
// A start request sets every belief to uniform and runs the partition; a
// received bit takes M divisions in the shared divider, then the partition.
// Once decoding has finished, a received bit skips the divisions and partition.
// Each partition round scans all M beliefs and then moves, for up to 2*M+1 rounds.
// Reset is synchronous and runs the start sequence, so in_ready stays low
// until that sequence is done. A result waits in the output register, and
// in_ready stays low until it leaves.
// ----------------------------------------------------------------------------
`include "feedback_decoder_belief_partition_unit_macros.svh"
module feedback_decoder_belief_partition_unit #(
  parameter int NUM_MESSAGES = fdbp_pkg::NUM_MESSAGES_DEF,
  parameter int BELIEF_FRAC_BITS = fdbp_pkg::BELIEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fdbp_if.sink                           in_ch,
  fdbp_if.source                         out_ch,
  input  logic                           cfg_we,
  input  logic [fdbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int M = NUM_MESSAGES;
  localparam int F = BELIEF_FRAC_BITS;
  localparam int BW = F + 1;
  localparam int IW = $clog2(M);
  localparam int PW = BW + 16;
  localparam int SW = PW + IW;
  localparam int MW = BW + 2;
  localparam int RW = $clog2(2 * M + 1);
  localparam logic [BW-1:0] ONE = BW'(1) << F;
  localparam logic [BW-1:0] UNI = BW'((64'd1 << F) / M);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SUM = 4'd2;
  localparam logic [3:0] S_DIV = 4'd3;
  localparam logic [3:0] S_DWAIT = 4'd4;
  localparam logic [3:0] S_MAX = 4'd5;
  localparam logic [3:0] S_PSTART = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_MOVE = 4'd8;
  localparam logic [3:0] S_FIN = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0]    st_r, st_nxt;
  logic [BW-1:0] bel_r [M];
  logic [M-1:0]  side_r;
  logic          s0_r;
  logic [M-1:0]  pmask_r;
  logic [11:0]   steps_r;
  logic          fin_r;
  logic          guard_r;
  logic          act_r, rx_r;
  logic [15:0]   xo_r;
  logic [24:0]   thr_r;
  logic [11:0]   maxs_r;
  logic [IW-1:0] i_r;
  logic [SW-1:0] sum_r;
  logic [BW-1:0] mx_r;
  logic [IW-1:0] mi_r;
  logic [BW-1:0] mn_r;
  logic [IW-1:0] mk_r;
  logic          have_r;
  logic signed [MW-1:0] m0_r, m1_r;
  logic [RW-1:0] rounds_r;
  logic          first_r;
  logic          ovld_r;
  fdbp_pkg::out_req_t opay_r;

  logic [PW-1:0] prod;
  logic          dstart, ddone;
  logic [BW-1:0] dq;
  logic          last_i;
  logic signed [MW-1:0] nm0, nm1;
  logic          part_stop, guard_stop;

  always_comb begin
    prod = PW'(bel_r[i_r]) * PW'((pmask_r[i_r] != rx_r) ? {1'b0, xo_r}
                                : (17'd65536 - {1'b0, xo_r}));
  end

  assign last_i = (i_r == IW'(M - 1));
  assign dstart = (st_r == S_DIV);
  assign nm0 = m0_r - MW'(mn_r);
  assign nm1 = m1_r + MW'(mn_r);
  assign part_stop = !have_r || !(MW'(mn_r) < (m0_r - m1_r));
  assign guard_stop = (rounds_r >= RW'(2 * M));

  fdbp_divider #(.NUM_W(SW), .FRAC(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart),
    .num(SW'(prod)), .den(sum_r), .done(ddone), .quot(dq)
  );

  assign in_ch.ready = (st_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.payload = opay_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) st_nxt = S_INIT;
      S_INIT: st_nxt = (act_r == fdbp_pkg::ACT_START || fin_r) ? S_MAX : S_SUM;
      S_SUM: if (last_i) st_nxt = ((sum_r + SW'(prod)) == '0) ? S_MAX : S_DIV;
      S_DIV: st_nxt = S_DWAIT;
      S_DWAIT: if (ddone) st_nxt = last_i ? S_MAX : S_DIV;
      S_MAX: if (last_i) st_nxt = (act_r == fdbp_pkg::ACT_BIT && fin_r) ? S_FIN : S_PSTART;
      S_PSTART: st_nxt = (mx_r >= (ONE >> 1)) ? S_FIN : S_SCAN;
      S_SCAN: if (last_i) st_nxt = S_MOVE;
      S_MOVE: st_nxt = (part_stop || guard_stop) ? S_FIN : S_SCAN;
      S_FIN: st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      act_r <= fdbp_pkg::ACT_START;
      rx_r <= 1'b0;
      first_r <= 1'b1;
      ovld_r <= 1'b0;
      xo_r <= fdbp_pkg::CROSSOVER_RST;
      thr_r <= fdbp_pkg::STOP_THRESHOLD_RST;
      maxs_r <= fdbp_pkg::MAX_STEPS_RST;
      fin_r <= 1'b0;
      steps_r <= '0;
      i_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdbp_pkg::REG_CROSSOVER: xo_r <= cfg_data[15:0];
          fdbp_pkg::REG_STOP_THRESHOLD: thr_r <= cfg_data[24:0];
          fdbp_pkg::REG_MAX_STEPS: maxs_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ovld_r <= 1'b0;
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            act_r <= in_ch.payload.action;
            rx_r <= in_ch.payload.rx_bit;
            first_r <= 1'b0;
          end
        end
        S_INIT: begin
          i_r <= '0;
          sum_r <= '0;
          if (act_r == fdbp_pkg::ACT_START) begin
            for (int k = 0; k < M; k++) bel_r[k] <= UNI;
            steps_r <= '0;
            fin_r <= 1'b0;
          end
        end
        S_SUM: begin
          sum_r <= sum_r + SW'(prod);
          i_r <= last_i ? '0 : i_r + 1'b1;
        end
        S_DWAIT: begin
          if (ddone) begin
            bel_r[i_r] <= dq;
            i_r <= last_i ? '0 : i_r + 1'b1;
          end
        end
        S_MAX: begin
          if (i_r == '0 || bel_r[i_r] > mx_r) begin
            mx_r <= bel_r[i_r];
            mi_r <= i_r;
          end
          i_r <= last_i ? '0 : i_r + 1'b1;
          if (last_i && act_r == fdbp_pkg::ACT_BIT && !fin_r && steps_r != 12'd4095)
            steps_r <= steps_r + 1'b1;
        end
        S_PSTART: begin
          guard_r <= 1'b0;
          side_r <= '0;
          s0_r <= 1'b0;
          m0_r <= MW'(ONE);
          m1_r <= '0;
          rounds_r <= '0;
          have_r <= 1'b0;
          i_r <= '0;
          if (mx_r >= (ONE >> 1)) begin
            pmask_r <= M'(1) << mi_r;
          end
        end
        S_SCAN: begin
          if (side_r[i_r] == s0_r && (!have_r || bel_r[i_r] < mn_r)) begin
            mn_r <= bel_r[i_r];
            mk_r <= i_r;
            have_r <= 1'b1;
          end
          i_r <= last_i ? '0 : i_r + 1'b1;
        end
        S_MOVE: begin
          have_r <= 1'b0;
          if (part_stop) begin
            pmask_r <= side_r ^ {M{s0_r}};
          end else if (guard_stop) begin
            guard_r <= 1'b1;
            pmask_r <= side_r ^ {M{s0_r}};
          end else begin
            rounds_r <= rounds_r + 1'b1;
            side_r[mk_r] <= ~s0_r;
            if (nm0 < nm1) begin
              m0_r <= nm1;
              m1_r <= nm0;
              s0_r <= ~s0_r;
            end else begin
              m0_r <= nm0;
              m1_r <= nm1;
            end
          end
        end
        S_FIN: begin
          opay_r.next_tx_mask <= 16'(pmask_r);
          opay_r.decoded_index <= 4'(mi_r);
          opay_r.max_belief <= 25'(mx_r);
          opay_r.steps_used <= steps_r;
          opay_r.decided <= (act_r == fdbp_pkg::ACT_BIT) && (25'(mx_r) > thr_r);
          if (act_r == fdbp_pkg::ACT_START) begin
            opay_r.status <= guard_r ? fdbp_pkg::ST_GUARD : fdbp_pkg::ST_OK;
          end else if (fin_r) begin
            opay_r.status <= fdbp_pkg::ST_IGNORED;
          end else if (25'(mx_r) > thr_r) begin
            fin_r <= 1'b1;
            opay_r.status <= guard_r ? fdbp_pkg::ST_GUARD : fdbp_pkg::ST_OK;
          end else if (steps_r >= maxs_r) begin
            fin_r <= 1'b1;
            opay_r.status <= fdbp_pkg::ST_TIMEOUT;
          end else begin
            opay_r.status <= guard_r ? fdbp_pkg::ST_GUARD : fdbp_pkg::ST_OK;
          end
        end
        S_OUT: begin
          ovld_r <= !first_r;
        end
        default: ;
      endcase
    end
  end

  `FDBP_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, st_r == S_IDLE, "ready while busy")
  `FDBP_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, st_r == S_INIT,
    "accepted request did not start")
  `FDBP_ASSERT_IMPL(a_out_idle, clk, rst_n, out_ch.valid, !in_ch.ready, "accept with result held")
endmodule
